// ===== sv/nkps_pkg.sv =====
package nkps_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Z = 2'd2;

  // fixed field widths
  localparam int TAG_W  = 10;
  localparam int KEPT_W = 4;

  // axis selector for the shared squarer
  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

endpackage

// ===== sv/nkps_ram.sv =====
module nkps_ram #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/nearest_k_point_selector_top.sv =====
// Keeps the SLOTS points nearest a reference position (ref_x/y/z, written
// through the cfg port by the user only while the block is idle, a rule
// unenforced by the block) by exact squared Euclidean distance on signed
// Q8.8 coordinates. The first SLOTS points of a set fill the slots in
// arrival order; after that a point replaces the farthest kept one only if
// strictly nearer, the lowest slot winning ties for farthest. An item with
// final_point set is processed like any other, then every slot is sent out
// in slot order (valid flag, tag, kept count, final_slot on the last one)
// and the selection clears itself. The distance is built on one shared
// squarer, three axes of difference, square and accumulate, and in_stall
// stays high from acceptance until the item is placed or, on a final item,
// every slot is sent out. Once all slots are full, a scan of the slot memory
// at one read a cycle finds the farthest entry, which is replaced if the
// item is strictly nearer. On a final item each slot result takes a memory
// read, then an output register load, plus any time out_stall is held. The
// output register lets the next item be accepted while the last result of a
// set still waits. Slot payloads sit in one small RAM; occupancy is a
// flip-flop per slot, cleared at reset and after each set, so no clearing pass is needed.
module nearest_k_point_selector_top #(
  parameter int SLOTS      = 8,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_point_x,
  input  logic signed [COORD_BITS-1:0]        in_point_y,
  input  logic signed [COORD_BITS-1:0]        in_point_z,
  input  logic [nkps_pkg::TAG_W-1:0]          in_point_tag,
  input  logic                                in_final_point,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_slot_valid,
  output logic [nkps_pkg::TAG_W-1:0]          out_chosen_tag,
  output logic [nkps_pkg::KEPT_W-1:0]         out_kept_count,
  output logic                                out_final_slot,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nkps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);

  localparam int TW     = nkps_pkg::TAG_W;
  localparam int KW     = nkps_pkg::KEPT_W;
  localparam int MAG_W  = COORD_BITS + 1;           // |difference|
  localparam int SQ_W   = 2 * MAG_W;                // one square
  localparam int DIST_W = SQ_W + 2;                 // sum of three squares
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ENT_W  = TW + DIST_W;              // {tag, distance}

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,     // difference magnitude of one axis
    S_SQR,      // shared squarer
    S_ACC,      // accumulate square
    S_PLACE,    // fill a free slot or start the scan
    S_SCAN,     // find farthest slot, one read a cycle
    S_REPL,     // replace farthest if strictly nearer
    S_EMIT_RD,  // read slot for output
    S_EMIT_LD   // load output register
  } state_t;

  state_t state_r, state_nxt;

  // reference position
  logic signed [COORD_BITS-1:0] ref_x_r, ref_x_nxt;
  logic signed [COORD_BITS-1:0] ref_y_r, ref_y_nxt;
  logic signed [COORD_BITS-1:0] ref_z_r, ref_z_nxt;

  // latched item
  logic signed [COORD_BITS-1:0] pt_x_r, pt_x_nxt;
  logic signed [COORD_BITS-1:0] pt_y_r, pt_y_nxt;
  logic signed [COORD_BITS-1:0] pt_z_r, pt_z_nxt;
  logic [TW-1:0]                tag_r, tag_nxt;
  logic                         last_r, last_nxt;

  // distance datapath
  nkps_pkg::axis_t              axis_r, axis_nxt;
  logic [MAG_W-1:0]             mag_r, mag_nxt;
  logic [SQ_W-1:0]              sq_r, sq_nxt;
  logic [DIST_W-1:0]            acc_r, acc_nxt;

  // selection state
  logic [SLOTS-1:0]             slot_used_r, slot_used_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;

  // scan
  logic [CNT_W-1:0]             issue_r, issue_nxt;
  logic                         pend_r, pend_nxt;
  logic [IDX_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic [DIST_W-1:0]            far_dist_r, far_dist_nxt;
  logic [IDX_W-1:0]             far_idx_r, far_idx_nxt;

  // emit
  logic [IDX_W-1:0]             emit_idx_r, emit_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_slot_valid_r, out_slot_valid_nxt;
  logic [TW-1:0]                out_tag_r, out_tag_nxt;
  logic [KW-1:0]                out_kept_r, out_kept_nxt;
  logic                         out_final_r, out_final_nxt;

  // slot memory
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [ENT_W-1:0]             ram_wdata;
  logic [IDX_W-1:0]             ram_raddr;
  logic [ENT_W-1:0]             ram_rdata;
  logic [DIST_W-1:0]            rd_dist;
  logic [TW-1:0]                rd_tag;

  logic                         in_take;
  logic                         issuing;
  logic signed [COORD_BITS-1:0] sel_pt, sel_ref;
  logic signed [MAG_W-1:0]      diff;

  nkps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_dist = ram_rdata[DIST_W-1:0];
  assign rd_tag  = ram_rdata[ENT_W-1:DIST_W];

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign issuing   = (issue_r < CNT_W'(SLOTS));

  assign out_valid      = out_valid_r;
  assign out_slot_valid = out_slot_valid_r;
  assign out_chosen_tag = out_tag_r;
  assign out_kept_count = out_kept_r;
  assign out_final_slot = out_final_r;

  // axis select for the shared difference / square path
  always_comb begin
    case (axis_r)
      nkps_pkg::AXIS_X: begin
        sel_pt  = pt_x_r;
        sel_ref = ref_x_r;
      end
      nkps_pkg::AXIS_Y: begin
        sel_pt  = pt_y_r;
        sel_ref = ref_y_r;
      end
      default: begin
        sel_pt  = pt_z_r;
        sel_ref = ref_z_r;
      end
    endcase
  end

  // exact difference, one bit wider than a coordinate
  assign diff = {sel_pt[COORD_BITS-1], sel_pt} - {sel_ref[COORD_BITS-1], sel_ref};

  // memory read port: scan address during the scan, emit address otherwise
  assign ram_raddr = (state_r == S_SCAN) ? issue_r[IDX_W-1:0] : emit_idx_r;

  always_comb begin
    state_nxt          = state_r;
    ref_x_nxt          = ref_x_r;
    ref_y_nxt          = ref_y_r;
    ref_z_nxt          = ref_z_r;
    pt_x_nxt           = pt_x_r;
    pt_y_nxt           = pt_y_r;
    pt_z_nxt           = pt_z_r;
    tag_nxt            = tag_r;
    last_nxt           = last_r;
    axis_nxt           = axis_r;
    mag_nxt            = mag_r;
    sq_nxt             = sq_r;
    acc_nxt            = acc_r;
    slot_used_nxt      = slot_used_r;
    cnt_nxt            = cnt_r;
    issue_nxt          = issue_r;
    pend_nxt           = 1'b0;
    rd_idx_nxt         = rd_idx_r;
    far_dist_nxt       = far_dist_r;
    far_idx_nxt        = far_idx_r;
    emit_idx_nxt       = emit_idx_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_slot_valid_nxt = out_slot_valid_r;
    out_tag_nxt        = out_tag_r;
    out_kept_nxt       = out_kept_r;
    out_final_nxt      = out_final_r;
    ram_we             = 1'b0;
    ram_waddr          = cnt_r[IDX_W-1:0];
    ram_wdata          = {tag_r, acc_r};

    // register writes, to be issued by the user only while idle, unenforced by the block
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nkps_pkg::CFG_REF_X: ref_x_nxt = cfg_data;
        nkps_pkg::CFG_REF_Y: ref_y_nxt = cfg_data;
        nkps_pkg::CFG_REF_Z: ref_z_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          pt_x_nxt  = in_point_x;
          pt_y_nxt  = in_point_y;
          pt_z_nxt  = in_point_z;
          tag_nxt   = in_point_tag;
          last_nxt  = in_final_point;
          axis_nxt  = nkps_pkg::AXIS_X;
          acc_nxt   = '0;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        mag_nxt   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        state_nxt = S_SQR;
      end
      S_SQR: begin
        sq_nxt    = mag_r * mag_r;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r + DIST_W'(sq_r);
        if (axis_r == nkps_pkg::AXIS_Z) begin
          state_nxt = S_PLACE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_DIFF;
        end
      end
      S_PLACE: begin
        if (cnt_r < CNT_W'(SLOTS)) begin
          // still filling: next free slot in arrival order
          ram_we                          = 1'b1;
          slot_used_nxt[cnt_r[IDX_W-1:0]] = 1'b1;
          cnt_nxt                         = cnt_r + 1'b1;
          state_nxt                       = last_r ? S_EMIT_RD : S_IDLE;
          emit_idx_nxt                    = '0;
        end else begin
          issue_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issuing) begin
          issue_nxt  = issue_r + 1'b1;
          pend_nxt   = 1'b1;
          rd_idx_nxt = issue_r[IDX_W-1:0];
        end
        if (pend_r) begin
          // strict greater keeps the lowest slot on ties
          if (rd_idx_r == '0 || rd_dist > far_dist_r) begin
            far_dist_nxt = rd_dist;
            far_idx_nxt  = rd_idx_r;
          end
          if (rd_idx_r == IDX_W'(SLOTS - 1)) begin
            state_nxt = S_REPL;
          end
        end
      end
      S_REPL: begin
        if (acc_r < far_dist_r) begin
          ram_we    = 1'b1;
          ram_waddr = far_idx_r;
        end
        emit_idx_nxt = '0;
        state_nxt    = last_r ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        // read only when the output register is free by the next edge
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        out_valid_nxt      = 1'b1;
        out_slot_valid_nxt = slot_used_r[emit_idx_r];
        out_tag_nxt        = slot_used_r[emit_idx_r] ? rd_tag : '0;
        out_kept_nxt       = KW'(cnt_r);
        out_final_nxt      = (emit_idx_r == IDX_W'(SLOTS - 1));
        if (emit_idx_r == IDX_W'(SLOTS - 1)) begin
          slot_used_nxt = '0;
          cnt_nxt       = '0;
          state_nxt     = S_IDLE;
        end else begin
          emit_idx_nxt = emit_idx_r + 1'b1;
          state_nxt    = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_x_r     <= '0;
      ref_y_r     <= '0;
      ref_z_r     <= '0;
      slot_used_r <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_x_r     <= ref_x_nxt;
      ref_y_r     <= ref_y_nxt;
      ref_z_r     <= ref_z_nxt;
      slot_used_r <= slot_used_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pt_x_r           <= pt_x_nxt;
    pt_y_r           <= pt_y_nxt;
    pt_z_r           <= pt_z_nxt;
    tag_r            <= tag_nxt;
    last_r           <= last_nxt;
    axis_r           <= axis_nxt;
    mag_r            <= mag_nxt;
    sq_r             <= sq_nxt;
    acc_r            <= acc_nxt;
    issue_r          <= issue_nxt;
    rd_idx_r         <= rd_idx_nxt;
    far_dist_r       <= far_dist_nxt;
    far_idx_r        <= far_idx_nxt;
    emit_idx_r       <= emit_idx_nxt;
    out_slot_valid_r <= out_slot_valid_nxt;
    out_tag_r        <= out_tag_nxt;
    out_kept_r       <= out_kept_nxt;
    out_final_r      <= out_final_nxt;
  end

  // occupancy flags and fill count always agree
  a_cnt_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_used_r) == 32'(cnt_r))
    else $error("fill count disagrees with occupied slots");

  // the fill count never passes the slot count
  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("fill count beyond slot count");

  // the farthest-slot scan only runs on a full selection
  a_scan_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r == CNT_W'(SLOTS)))
    else $error("scan started on a partly filled selection");

  // a pending scan read is only consumed inside the scan
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN))
    else $error("scan read pending outside the scan");

  // an output load never overwrites a result still held by a stall
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_LD) |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

endmodule

// ===== dv/testbench.sv =====
module testbench;

  localparam int SLOTS         = 8;
  localparam int COORD_W       = 16;
  localparam int RANDOM_POINTS = 140;
  // one distance plus the farthest-slot scan, with margin
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;
  // index past ref_z, a write there must leave the reference untouched
  localparam logic [nkps_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [nkps_pkg::TAG_W-1:0] tag_t;
  // exact sum of three squared differences, 36 bits at 16-bit coordinates
  typedef logic [35:0] sq_range_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    tag_t   tag;
    logic   last;
  } point_t;

  typedef struct packed {
    logic                        slot_valid;
    tag_t                        tag;
    logic [nkps_pkg::KEPT_W-1:0] kept;
    logic                        final_slot;
  } slot_result_t;

  typedef enum logic {ROW_POINT, ROW_CFG} row_kind_t;

  // one line of the directed plan; config rows carry their write data in pt.x
  typedef struct packed {
    row_kind_t                      kind;
    logic [nkps_pkg::CFG_IDX_W-1:0] cfg_idx;
    point_t                         pt;
    logic                           typed;
    logic [nkps_pkg::KEPT_W-1:0]    exp_kept;
    tag_t                           exp_tag;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  coord_t            in_point_x;
  coord_t            in_point_y;
  coord_t            in_point_z;
  tag_t              in_point_tag;
  logic              in_final_point;
  logic              out_valid;
  logic              out_stall;
  logic              out_slot_valid;
  tag_t              out_chosen_tag;
  logic [nkps_pkg::KEPT_W-1:0] out_kept_count;
  logic              out_final_slot;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [nkps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  // shadow of the block: reference position and the current selection
  coord_t       ref_pos [3];
  tag_t         kept_tag [SLOTS];
  sq_range_t    kept_range [SLOTS];
  logic         kept_used [SLOTS];
  int unsigned  kept_total;
  slot_result_t results_due [$];

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned points_sent  = 0;
  int unsigned sets_sent    = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int          burst_left   = 0;
  int          stall_mode   = 0;
  int          stall_left   = 0;

  nearest_k_point_selector_top #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_point_tag   (in_point_tag),
    .in_final_point (in_final_point),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_valid (out_slot_valid),
    .out_chosen_tag (out_chosen_tag),
    .out_kept_count (out_kept_count),
    .out_final_slot (out_final_slot),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // square of one axis difference, exact on the widened signed difference
  function automatic sq_range_t axis_sq(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return sq_range_t'(d * d);
  endfunction

  function automatic void clear_selection();
    for (int k = 0; k < SLOTS; k++) begin
      kept_tag[k]   = '0;
      kept_range[k] = '0;
      kept_used[k]  = 1'b0;
    end
    kept_total = 0;
  endfunction

  // folds one accepted point into the selection; on the last point of a set
  // it queues one result per slot (when predicted) and clears the selection
  function automatic void select_nearest(point_t p, bit predicted);
    sq_range_t    r;
    sq_range_t    far_r;
    int           far_k;
    slot_result_t res;
    r = axis_sq(p.x, ref_pos[0]) + axis_sq(p.y, ref_pos[1]) + axis_sq(p.z, ref_pos[2]);
    if (kept_total < SLOTS) begin
      // still filling: slots are taken in arrival order
      kept_tag[kept_total]   = p.tag;
      kept_range[kept_total] = r;
      kept_used[kept_total]  = 1'b1;
      kept_total++;
    end else begin
      // strict compare keeps the lowest slot as farthest among equals
      far_k = 0;
      far_r = kept_range[0];
      for (int k = 1; k < SLOTS; k++) begin
        if (kept_range[k] > far_r) begin
          far_r = kept_range[k];
          far_k = k;
        end
      end
      // a point only as far as the farthest one does not displace it
      if (r < far_r) begin
        kept_tag[far_k]   = p.tag;
        kept_range[far_k] = r;
      end
    end
    if (p.last) begin
      if (predicted) begin
        for (int k = 0; k < SLOTS; k++) begin
          res.slot_valid = kept_used[k];
          res.tag        = kept_used[k] ? kept_tag[k] : tag_t'(0);
          res.kept       = kept_total[nkps_pkg::KEPT_W-1:0];
          res.final_slot = (k == SLOTS - 1);
          results_due    = {results_due, res};
        end
      end
      clear_selection();
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  function automatic stim_row_t pt_row(coord_t x, coord_t y, coord_t z, tag_t tag,
                                       logic last);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_POINT;
    row.pt       = '{x, y, z, tag, last};
    return row;
  endfunction

  // a single-point set whose results can be written down by hand
  function automatic stim_row_t one_row(coord_t x, coord_t y, coord_t z, tag_t tag);
    stim_row_t row;
    row          = pt_row(x, y, z, tag, 1'b1);
    row.typed    = 1'b1;
    row.exp_kept = 4'd1;
    row.exp_tag  = tag;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [nkps_pkg::CFG_IDX_W-1:0] idx, coord_t data);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.cfg_idx = idx;
    row.pt.x    = data;
    return row;
  endfunction

  // spread 0: anywhere, 1: within a few lsb of the centre (plenty of ties),
  // 2: a moderate cloud round the centre, otherwise the extremes
  function automatic coord_t pick_coord(coord_t centre, int spread);
    case (spread)
      0: return coord_t'($urandom);
      1: return centre + coord_t'($urandom_range(0, 6)) - coord_t'(3);
      2: return centre + coord_t'($urandom_range(0, 4000)) - coord_t'(2000);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return centre;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  // sender: bursts of random length, random gaps between them; the payload
  // is held until the block takes it
  task automatic send_point(point_t p, bit predicted);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_valid       = 1'b1;
    in_point_x     = p.x;
    in_point_y     = p.y;
    in_point_z     = p.z;
    in_point_tag   = p.tag;
    in_final_point = p.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    select_nearest(p, predicted);
    points_sent++;
    if (p.last) sets_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_ref(logic [nkps_pkg::CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      nkps_pkg::CFG_REF_X: ref_pos[0] = data;
      nkps_pkg::CFG_REF_Y: ref_pos[1] = data;
      nkps_pkg::CFG_REF_Z: ref_pos[2] = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drains every pending result, then lets a point that produces none finish
  task automatic wait_idle();
    in_valid   = 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // receiver: stall pattern switches between none, light and heavy stalls
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // ---------------------------------------------------------------------
  // result checking against the oldest pending expectation
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, slot_result_t due, slot_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch (%s) at cycle %0d: expected valid=%0b tag=%0d kept=%0d last=%0b,",
               what, cycle_count, due.slot_valid, due.tag, due.kept, due.final_slot);
      $display("  got valid=%0b tag=%0d kept=%0d last=%0b",
               got.slot_valid, got.tag, got.kept, got.final_slot);
    end
  endtask

  always @(posedge clk) begin
    slot_result_t due;
    slot_result_t got;
    got = '{out_slot_valid, out_chosen_tag, out_kept_count, out_final_slot};
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch("unexpected item", '0, got);
      end else begin
        due = results_due.pop_front();
        if (got.slot_valid !== due.slot_valid || got.tag !== due.tag ||
            got.kept !== due.kept || got.final_slot !== due.final_slot) begin
          report_mismatch("field", due, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results still pending", results_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    stim_row_t                      plan [$];
    stim_row_t                      row;
    point_t                         p;
    slot_result_t                   res;
    logic [nkps_pkg::CFG_IDX_W-1:0] idx;
    int                             set_len;
    int                             spread;
    int                             mid_at;
    int unsigned                    directed_points;

    // every input known from time zero
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_point_x     = '0;
    in_point_y     = '0;
    in_point_z     = '0;
    in_point_tag   = '0;
    in_final_point = 1'b0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = nkps_pkg::CFG_REF_X;
    cfg_data       = '0;
    for (int a = 0; a < 3; a++) ref_pos[a] = '0;
    clear_selection();

    // directed plan, reference at the origin after reset
    // lone points at both corners of the range: results known by hand
    plan = {plan, one_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 10'd1023)};
    plan = {plan, one_row(16'sh8000, 16'sh8000, 16'sh8000, 10'd0)};
    // write to the unused index must not move the reference
    plan = {plan, cfg_row(CFG_UNUSED, 16'sh7FFF)};
    // fill all slots with ties for farthest (slots 1, 2 and 5 all at 25)
    plan = {plan, pt_row(16'sd3, 16'sd0, 16'sd0, 10'd10, 1'b0)};
    plan = {plan, pt_row(16'sd5, 16'sd0, 16'sd0, 10'd11, 1'b0)};
    plan = {plan, pt_row(16'sd0, 16'sd5, 16'sd0, 10'd12, 1'b0)};
    plan = {plan, pt_row(16'sd1, 16'sd0, 16'sd0, 10'd13, 1'b0)};
    plan = {plan, pt_row(16'sd0, 16'sd0, 16'sd2, 10'd14, 1'b0)};
    plan = {plan, pt_row(16'sd0, 16'sd0, -16'sd5, 10'd15, 1'b0)};
    plan = {plan, pt_row(16'sd4, 16'sd0, 16'sd0, 10'd16, 1'b0)};
    plan = {plan, pt_row(16'sd0, 16'sd0, 16'sd0, 10'd17, 1'b0)};
    // equally far: no replacement
    plan = {plan, pt_row(-16'sd5, 16'sd0, 16'sd0, 10'd18, 1'b0)};
    // nearer: replaces the lowest of the tied farthest slots
    plan = {plan, pt_row(16'sd2, 16'sd0, 16'sd0, 10'd19, 1'b0)};
    // final point is itself a candidate before the selection goes out
    plan = {plan, pt_row(16'sd0, -16'sd1, 16'sd0, 10'd20, 1'b1)};
    // reference at the far corner, farthest possible point
    plan = {plan, cfg_row(nkps_pkg::CFG_REF_X, 16'sh7FFF)};
    plan = {plan, cfg_row(nkps_pkg::CFG_REF_Y, 16'sh7FFF)};
    plan = {plan, cfg_row(nkps_pkg::CFG_REF_Z, 16'sh8000)};
    plan = {plan, pt_row(16'sh8000, 16'sh8000, 16'sh7FFF, 10'd21, 1'b0)};
    // reference moves mid-set, kept distance stays as it was
    plan = {plan, cfg_row(nkps_pkg::CFG_REF_X, 16'sh0000)};
    plan = {plan, pt_row(16'sd0, 16'sd0, 16'sd0, 10'd22, 1'b1)};
    // exactly SLOTS points, last one final: full selection, no scan
    plan = {plan, pt_row(16'sh7FFF, 16'sh0000, 16'sh8000, 10'd30, 1'b0)};
    plan = {plan, pt_row(16'sh8000, 16'sh7FFF, 16'sh0000, 10'd31, 1'b0)};
    plan = {plan, pt_row(16'sh0100, 16'sh7FFF, 16'sh8000, 10'd32, 1'b0)};
    plan = {plan, pt_row(-16'sh0100, 16'sh7FFF, 16'sh8000, 10'd33, 1'b0)};
    plan = {plan, pt_row(16'sh5555, 16'sh2AAA, 16'sh8001, 10'd341, 1'b0)};
    plan = {plan, pt_row(16'sh2AAA, 16'sh5555, 16'shFFFF, 10'd682, 1'b0)};
    plan = {plan, pt_row(16'sh0001, 16'sh7FFE, 16'sh8000, 10'd512, 1'b0)};
    plan = {plan, pt_row(16'shFFFF, 16'sh0000, 16'sh7FFF, 10'd511, 1'b1)};

    // synchronous reset, then release
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_ref(row.cfg_idx, row.pt.x);
      end else begin
        send_point(row.pt, !row.typed);
        if (row.typed) begin
          for (int k = 0; k < SLOTS; k++) begin
            res.slot_valid = (k == 0);
            res.tag        = (k == 0) ? row.exp_tag : tag_t'(0);
            res.kept       = row.exp_kept;
            res.final_slot = (k == SLOTS - 1);
            results_due    = {results_due, res};
          end
        end
      end
    end
    directed_points = points_sent;

    // random sets: mostly long enough to fill every slot and force
    // replacements, with the odd short set and reference moves in between
    while (points_sent < directed_points + RANDOM_POINTS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        repeat ($urandom_range(1, 3)) begin
          idx = $urandom_range(0, 3);
          write_ref(idx, pick_coord('0, ($urandom_range(0, 1) == 0) ? 0 : 3));
        end
      end
      set_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 20);
      spread  = $urandom_range(0, 3);
      mid_at  = -1;
      if (set_len > 1 && $urandom_range(0, 7) == 0) mid_at = $urandom_range(0, set_len - 2);
      for (int n = 0; n < set_len; n++) begin
        p.x    = pick_coord(ref_pos[0], spread);
        p.y    = pick_coord(ref_pos[1], spread);
        p.z    = pick_coord(ref_pos[2], spread);
        p.tag  = $urandom_range(0, 1023);
        p.last = (n == set_len - 1);
        send_point(p, 1'b1);
        if (n == mid_at) begin
          wait_idle();
          idx = $urandom_range(0, 2);
          write_ref(idx, pick_coord(ref_pos[idx], 2));
        end
      end
    end

    wait_idle();
    $display("%0d points in %0d sets, %0d slot results checked, %0d register writes",
             points_sent, sets_sent, results_seen, cfg_writes);
    $display("%0d failures over %0d cycles", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/nkps_pkg.sv
sv/nkps_ram.sv
sv/nearest_k_point_selector_top.sv
dv/testbench.sv
